// ===== rtl/core/unit_vector_with_derivatives_assert.svh =====
// Assertion macros shared by the unit vector RTL.
`ifndef UNIT_VECTOR_WITH_DERIVATIVES_ASSERT_SVH
`define UNIT_VECTOR_WITH_DERIVATIVES_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define UVD_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// Implication after a delay given by dly.
`define UVD_ASSERT_DLY(lbl, ck, rs, ante, dly, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> ## dly (cons)) else $error(msg);
`else
`define UVD_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define UVD_ASSERT_DLY(lbl, ck, rs, ante, dly, cons, msg)
`endif
`endif

// ===== rtl/core/uvd_pkg.sv =====
// Shared types, constants and helper functions of the unit vector block.
`default_nettype none
package uvd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IFRAC = 30;
  localparam int LANES = 9;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 63;
  localparam int NORM_LAT = SQRT_STEPS + 4;
  localparam int DIV_LAT = DIV_STEPS + 2;
  localparam int MUL_LAT = 3;
  localparam int ALG_LAT = 17;

  // Internal values are signed Q30 limited to magnitude 2^60.
  localparam int QW = 62;
  localparam int MW = 61;
  typedef logic signed [QW-1:0] qv_t;
  typedef logic [MW-1:0] qmag_t;

  localparam qv_t QLIM = {2'b01, 60'd0};
  localparam logic signed [63:0] LIM64 = 64'sh1000_0000_0000_0000;

  // Magnitude of an internal value.
  function automatic qmag_t qmag(input qv_t x);
    logic [QW-1:0] t;
    t = x[QW-1] ? (-x) : x;
    return t[MW-1:0];
  endfunction

  // Limit a widened sum to the internal range.
  function automatic qv_t clampq(input logic signed [63:0] x);
    if (x > LIM64) begin
      return QLIM;
    end else if (x < -LIM64) begin
      return -QLIM;
    end else begin
      return x[QW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/uvd_dly.sv =====
// Fixed-length delay line used to align operands across the pipeline.
`default_nettype none
module uvd_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] sr [D];

  // Shift one place per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) begin
        sr[i] <= '0;
      end
    end else begin
      sr[0] <= d;
      for (int i = 1; i < D; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[D-1];

endmodule
`default_nettype wire

// ===== rtl/core/uvd_norm.sv =====
// Squared length, even normalizing shift and pipelined integer square root.
`default_nettype none
module uvd_norm (
  input  wire logic               clk,
  input  wire logic signed [31:0] vx,
  input  wire logic signed [31:0] vy,
  input  wire logic signed [31:0] vz,
  output logic             [31:0] n,
  output logic             [4:0]  k,
  output logic                    zero
);

  localparam int SQ = uvd_pkg::SQRT_STEPS;

  logic [31:0] ma [3];
  logic [63:0] sq [3];
  logic [63:0] s1;
  logic        z1;
  logic [63:0] s2;
  logic [4:0]  k2;
  logic        z2;
  logic [4:0]  k_next;

  logic [63:0] vv [SQ+1];
  logic [33:0] rm [SQ+1];
  logic [31:0] rt [SQ+1];
  logic [4:0]  kp [SQ+1];
  logic        zp [SQ+1];
  logic [35:0] rsh [SQ];
  logic [35:0] trial [SQ];
  logic        take [SQ];

  // Component magnitudes.
  always_comb begin
    ma[0] = vx[31] ? (32'd0 - vx) : vx;
    ma[1] = vy[31] ? (32'd0 - vy) : vy;
    ma[2] = vz[31] ? (32'd0 - vz) : vz;
  end

  // Smallest even shift that lifts the sum to at least 2^60.
  always_comb begin
    k_next = '0;
    for (int j = 30; j >= 0; j--) begin
      if ((s1 >> (60 - 2 * j)) != 64'd0) begin
        k_next = 5'(j);
      end
    end
  end

  // One root bit per step: compare the running remainder with the trial value.
  always_comb begin
    for (int j = 0; j < SQ; j++) begin
      rsh[j] = {rm[j], vv[j][63:62]};
      trial[j] = {2'b00, rt[j], 2'b01};
      take[j] = rsh[j] >= trial[j];
    end
  end

  // Squares, sum, shift and square-root stages.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= ma[i] * ma[i];
    end
    s1 <= sq[0] + sq[1] + sq[2];
    z1 <= (sq[0] | sq[1] | sq[2]) == 64'd0;
    s2 <= s1;
    k2 <= k_next;
    z2 <= z1;
    vv[0] <= s2 << {k2, 1'b0};
    rm[0] <= '0;
    rt[0] <= '0;
    kp[0] <= k2;
    zp[0] <= z2;
    for (int j = 0; j < SQ; j++) begin
      if (take[j]) begin
        rm[j+1] <= 34'(rsh[j] - trial[j]);
        rt[j+1] <= {rt[j][30:0], 1'b1};
      end else begin
        rm[j+1] <= rsh[j][33:0];
        rt[j+1] <= {rt[j][30:0], 1'b0};
      end
      vv[j+1] <= {vv[j][61:0], 2'b00};
      kp[j+1] <= kp[j];
      zp[j+1] <= zp[j];
    end
  end

  assign n = rt[SQ];
  assign k = kp[SQ];
  assign zero = zp[SQ];

endmodule
`default_nettype wire

// ===== rtl/core/uvd_div.sv =====
// Pipelined rounded division of nine components by the norm, one quotient bit per stage.
`default_nettype none
module uvd_div (
  input  wire logic                                   clk,
  input  wire logic [31:0]                            n,
  input  wire logic [4:0]                             k,
  input  wire logic [uvd_pkg::LANES-1:0][31:0]        val,
  output uvd_pkg::qv_t [uvd_pkg::LANES-1:0]           quo
);

  localparam int L = uvd_pkg::LANES;
  localparam int DS = uvd_pkg::DIV_STEPS;

  logic [31:0] nn [DS+1];
  logic [4:0]  kk [DS+1];
  logic [31:0] mm [L][DS+1];
  logic        ng [L][DS+1];
  logic        ov [L][DS+1];
  logic [31:0] rr [L][DS+1];
  logic [DS-1:0] qq [L][DS+1];
  logic [31:0] m0 [L];
  logic [31:0] r0 [L];
  logic        dbit [L][DS];
  logic [32:0] rsh [L][DS];
  logic        ge [L][DS];
  logic        sat [L];
  logic [DS:0] qp1 [L];
  uvd_pkg::qmag_t qm [L];
  int          bp;

  // Magnitudes and the part of the dividend above the quotient bits.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      m0[l] = val[l][31] ? (32'd0 - val[l]) : val[l];
      r0[l] = m0[l] >> (6'd32 - 6'(k));
    end
  end

  // Dividend bit, shifted remainder and compare for each step.
  always_comb begin
    bp = 0;
    for (int l = 0; l < L; l++) begin
      for (int s = 0; s < DS; s++) begin
        bp = 31 - s - int'(kk[s]);
        dbit[l][s] = (bp >= 0) ? mm[l][s][bp[4:0]] : 1'b0;
        rsh[l][s] = {rr[l][s], dbit[l][s]};
        ge[l][s] = rsh[l][s] >= {1'b0, nn[s]};
      end
    end
  end

  // Rounding half away from zero and saturation at 2^60.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      qp1[l] = {1'b0, qq[l][DS]} + 64'd1;
      sat[l] = ov[l][DS] || (qq[l][DS] > {2'b01, 61'd0});
      qm[l] = sat[l] ? uvd_pkg::qmag_t'({1'b1, 60'd0}) : qp1[l][uvd_pkg::MW:1];
    end
  end

  // Set-up stage, division steps and output stage.
  always_ff @(posedge clk) begin
    nn[0] <= n;
    kk[0] <= k;
    for (int l = 0; l < L; l++) begin
      mm[l][0] <= m0[l];
      ng[l][0] <= val[l][31];
      ov[l][0] <= r0[l] >= n;
      rr[l][0] <= r0[l];
      qq[l][0] <= '0;
    end
    for (int s = 0; s < DS; s++) begin
      nn[s+1] <= nn[s];
      kk[s+1] <= kk[s];
      for (int l = 0; l < L; l++) begin
        mm[l][s+1] <= mm[l][s];
        ng[l][s+1] <= ng[l][s];
        ov[l][s+1] <= ov[l][s];
        rr[l][s+1] <= ge[l][s] ? 32'(rsh[l][s] - {1'b0, nn[s]}) : rsh[l][s][31:0];
        qq[l][s+1] <= {qq[l][s][DS-2:0], ge[l][s]};
      end
    end
    for (int l = 0; l < L; l++) begin
      quo[l] <= ng[l][DS] ? -$signed({1'b0, qm[l]}) : $signed({1'b0, qm[l]});
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/uvd_mul.sv =====
// Three-stage Q30 multiplier with rounding and saturation at 2^60.
`default_nettype none
module uvd_mul (
  input  wire logic          clk,
  input  wire uvd_pkg::qv_t  a,
  input  wire uvd_pkg::qv_t  b,
  output uvd_pkg::qv_t       p
);

  uvd_pkg::qmag_t ma;
  uvd_pkg::qmag_t mb;
  logic [63:0]  pll;
  logic [60:0]  plh;
  logic [60:0]  phl;
  logic [57:0]  phh;
  logic         ng1;
  logic [120:0] prod;
  logic         ng2;
  logic [90:0]  rnd;
  uvd_pkg::qmag_t rm;

  always_comb begin
    ma = uvd_pkg::qmag(a);
    mb = uvd_pkg::qmag(b);
  end

  // Rounded shift and limit of the full product.
  always_comb begin
    rnd = 91'((prod + (121'd1 << (uvd_pkg::IFRAC - 1))) >> uvd_pkg::IFRAC);
    rm = (rnd > {30'd0, 1'b1, 60'd0}) ? uvd_pkg::qmag_t'({1'b1, 60'd0}) : rnd[60:0];
  end

  // Partial products, their sum, then the rounded signed result.
  always_ff @(posedge clk) begin
    pll <= ma[31:0] * mb[31:0];
    plh <= ma[31:0] * mb[60:32];
    phl <= ma[60:32] * mb[31:0];
    phh <= ma[60:32] * mb[60:32];
    ng1 <= a[uvd_pkg::QW-1] ^ b[uvd_pkg::QW-1];
    prod <= 121'(pll) + (121'(plh) << 32) + (121'(phl) << 32) + (121'(phh) << 64);
    ng2 <= ng1;
    p <= ng2 ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
  end

endmodule
`default_nettype wire

// ===== rtl/core/unit_vector_with_derivatives.sv =====
// Top level: unit vector of A with its first and second time derivatives.
//
// One vector set is taken in every clock cycle (busy is always low) and its
// result appears with done after the squared length, normalizing shift and the
// 32-step square root, then the 63-step divider that scales all nine components
// by the norm, and last the Q30 product and sum network. The result is shown
// for one cycle only; the receiver must take it then. For a zero vector all
// outputs are zero and degenerate is set.
`default_nettype none
`include "unit_vector_with_derivatives_assert.svh"
module unit_vector_with_derivatives #(
  parameter int FRAC_BITS = uvd_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] vec_x,
  input  wire logic signed [31:0] vec_y,
  input  wire logic signed [31:0] vec_z,
  input  wire logic signed [31:0] rate_x,
  input  wire logic signed [31:0] rate_y,
  input  wire logic signed [31:0] rate_z,
  input  wire logic signed [31:0] accel_x,
  input  wire logic signed [31:0] accel_y,
  input  wire logic signed [31:0] accel_z,
  output logic                    done,
  output logic signed [31:0]      unit_x,
  output logic signed [31:0]      unit_y,
  output logic signed [31:0]      unit_z,
  output logic signed [31:0]      unit_rate_x,
  output logic signed [31:0]      unit_rate_y,
  output logic signed [31:0]      unit_rate_z,
  output logic signed [31:0]      unit_accel_x,
  output logic signed [31:0]      unit_accel_y,
  output logic signed [31:0]      unit_accel_z,
  output logic                    degenerate
);

  localparam int SH = uvd_pkg::IFRAC - FRAC_BITS;
  localparam int QW = uvd_pkg::QW;
  localparam int TOTAL_LAT = uvd_pkg::NORM_LAT + uvd_pkg::DIV_LAT + uvd_pkg::ALG_LAT;

  logic                             beat_in;
  logic [uvd_pkg::LANES-1:0][31:0]  in_pack;
  logic [uvd_pkg::LANES-1:0][31:0]  in_dly;
  logic [31:0]                      norm_n;
  logic [4:0]                       norm_k;
  logic                             norm_zero;
  logic                             v_n;
  logic                             v_d;
  logic                             v_o;
  logic                             deg16;
  uvd_pkg::qv_t [uvd_pkg::LANES-1:0] quo;
  uvd_pkg::qv_t [2:0] qv, rv, cv;
  uvd_pkg::qv_t [2:0] q4, q12, q16, r7, c7;
  uvd_pkg::qv_t [2:0] pqr, pqc, pqrho, pqgam;
  uvd_pkg::qv_t [2:0] rp, cp, rp16, cp15;
  uvd_pkg::qv_t [2:0] prr, prhorp, rhorp15, pqw, qdd;
  uvd_pkg::qv_t       rho, gam, rho8, w;

  // Scale a Q30 value to the output format with rounding and saturation.
  function automatic logic signed [31:0] to_out(input uvd_pkg::qv_t x);
    logic [QW-1:0] rs;
    rs = (QW'(uvd_pkg::qmag(x)) + (QW'(1) << (SH - 1))) >> SH;
    if (x[QW-1]) begin
      if (rs > QW'(33'h1_0000_0000 >> 1)) begin
        return 32'sh8000_0000;
      end else begin
        return 32'(33'd0 - rs[32:0]);
      end
    end else if (rs > QW'(32'h7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else begin
      return rs[31:0];
    end
  endfunction

  // The block never stalls the sender.
  assign busy = 1'b0;
  assign beat_in = start && !busy;
  assign in_pack = {accel_z, accel_y, accel_x, rate_z, rate_y, rate_x, vec_z, vec_y, vec_x};

  // Norm pipeline and input alignment.
  uvd_norm u_norm (
    .clk (clk), .vx (vec_x), .vy (vec_y), .vz (vec_z),
    .n (norm_n), .k (norm_k), .zero (norm_zero)
  );

  uvd_dly #(.W(uvd_pkg::LANES * 32), .D(uvd_pkg::NORM_LAT)) u_in_dly (
    .clk (clk), .rst (rst), .d (in_pack), .q (in_dly)
  );

  // Valid bits and the zero-vector flag follow the data.
  uvd_dly #(.W(1), .D(uvd_pkg::NORM_LAT)) u_vn (
    .clk (clk), .rst (rst), .d (beat_in), .q (v_n)
  );
  uvd_dly #(.W(1), .D(uvd_pkg::DIV_LAT)) u_vd (
    .clk (clk), .rst (rst), .d (v_n), .q (v_d)
  );
  uvd_dly #(.W(1), .D(uvd_pkg::ALG_LAT)) u_vo (
    .clk (clk), .rst (rst), .d (v_d), .q (v_o)
  );
  uvd_dly #(.W(1), .D(uvd_pkg::DIV_LAT + uvd_pkg::ALG_LAT - 1)) u_deg (
    .clk (clk), .rst (rst), .d (norm_zero), .q (deg16)
  );

  // Divide all nine components by the norm.
  uvd_div u_div (
    .clk (clk), .n (norm_n), .k (norm_k), .val (in_dly), .quo (quo)
  );

  assign qv = quo[2:0];
  assign rv = quo[5:3];
  assign cv = quo[8:6];

  // Operand alignment for the product network.
  uvd_dly #(.W(3 * QW), .D(4)) u_q4 (.clk (clk), .rst (rst), .d (qv), .q (q4));
  uvd_dly #(.W(3 * QW), .D(8)) u_q12 (.clk (clk), .rst (rst), .d (q4), .q (q12));
  uvd_dly #(.W(3 * QW), .D(4)) u_q16 (.clk (clk), .rst (rst), .d (q12), .q (q16));
  uvd_dly #(.W(3 * QW), .D(7)) u_r7 (.clk (clk), .rst (rst), .d (rv), .q (r7));
  uvd_dly #(.W(3 * QW), .D(7)) u_c7 (.clk (clk), .rst (rst), .d (cv), .q (c7));
  uvd_dly #(.W(QW), .D(4)) u_rho8 (.clk (clk), .rst (rst), .d (rho), .q (rho8));
  uvd_dly #(.W(3 * QW), .D(8)) u_rp16 (.clk (clk), .rst (rst), .d (rp), .q (rp16));
  uvd_dly #(.W(3 * QW), .D(7)) u_cp15 (.clk (clk), .rst (rst), .d (cp), .q (cp15));
  uvd_dly #(.W(3 * QW), .D(4)) u_rr15 (.clk (clk), .rst (rst), .d (prhorp), .q (rhorp15));

  // Product units for each component.
  for (genvar i = 0; i < 3; i++) begin : g_mul
    uvd_mul u_qr (.clk (clk), .a (qv[i]), .b (rv[i]), .p (pqr[i]));
    uvd_mul u_qc (.clk (clk), .a (qv[i]), .b (cv[i]), .p (pqc[i]));
    uvd_mul u_qrho (.clk (clk), .a (q4[i]), .b (rho), .p (pqrho[i]));
    uvd_mul u_qgam (.clk (clk), .a (q4[i]), .b (gam), .p (pqgam[i]));
    uvd_mul u_rr (.clk (clk), .a (rp[i]), .b (rp[i]), .p (prr[i]));
    uvd_mul u_rhorp (.clk (clk), .a (rho8), .b (rp[i]), .p (prhorp[i]));
    uvd_mul u_qw (.clk (clk), .a (q12[i]), .b (w), .p (pqw[i]));
  end

  // Dot products, projections, second-derivative sum and output scaling.
  always_ff @(posedge clk) begin
    rho <= uvd_pkg::clampq(64'($signed(pqr[0])) + 64'($signed(pqr[1]))
                           + 64'($signed(pqr[2])));
    gam <= uvd_pkg::clampq(64'($signed(pqc[0])) + 64'($signed(pqc[1]))
                           + 64'($signed(pqc[2])));
    w <= uvd_pkg::clampq(64'($signed(prr[0])) + 64'($signed(prr[1]))
                         + 64'($signed(prr[2])));
    for (int i = 0; i < 3; i++) begin
      rp[i] <= uvd_pkg::clampq(64'($signed(r7[i])) - 64'($signed(pqrho[i])));
      cp[i] <= uvd_pkg::clampq(64'($signed(c7[i])) - 64'($signed(pqgam[i])));
      qdd[i] <= uvd_pkg::clampq(64'($signed(cp15[i])) - (64'($signed(rhorp15[i])) <<< 1)
                                - 64'($signed(pqw[i])));
    end
    unit_x <= deg16 ? 32'sd0 : to_out(q16[0]);
    unit_y <= deg16 ? 32'sd0 : to_out(q16[1]);
    unit_z <= deg16 ? 32'sd0 : to_out(q16[2]);
    unit_rate_x <= deg16 ? 32'sd0 : to_out(rp16[0]);
    unit_rate_y <= deg16 ? 32'sd0 : to_out(rp16[1]);
    unit_rate_z <= deg16 ? 32'sd0 : to_out(rp16[2]);
    unit_accel_x <= deg16 ? 32'sd0 : to_out(qdd[0]);
    unit_accel_y <= deg16 ? 32'sd0 : to_out(qdd[1]);
    unit_accel_z <= deg16 ? 32'sd0 : to_out(qdd[2]);
    degenerate <= deg16;
  end

  assign done = v_o;

  // A nonzero vector always normalizes into the top two bits of the root.
  `UVD_ASSERT_IMP(a_norm_range, clk, rst, v_n && !norm_zero, norm_n[31] || norm_n[30], "norm below 2^30")
  // The first scaled vector component stays within the internal limit.
  `UVD_ASSERT_IMP(a_quo_range, clk, rst, v_d, $signed(qv[0]) <= $signed(uvd_pkg::QLIM) && $signed(qv[0]) >= -$signed(uvd_pkg::QLIM), "scaled component out of range")
  // Every accepted beat produces a result once it has passed the norm, divider and product stages.
  `UVD_ASSERT_DLY(a_latency, clk, rst, beat_in, TOTAL_LAT, done, "result missing")
  // A degenerate result carries zero unit, rate and accel x fields.
  `UVD_ASSERT_IMP(a_deg_zero, clk, rst, done && degenerate, unit_x == 0 && unit_rate_x == 0 && unit_accel_x == 0, "degenerate result not zero")

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the unit vector block: random and corner vector sets against a predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1935;
  localparam int DRAIN_POINT = 1000;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SH_OUT = uvd_pkg::IFRAC - uvd_pkg::FRAC_BITS_DEF;
  localparam logic [63:0] LIM_U = 64'd1 << 60;
  localparam longint LIM_S = longint'(64'd1 << 60);

  typedef logic signed [31:0] word_t;

  typedef struct {
    word_t vec[3];
    word_t rate[3];
    word_t accel[3];
  } vec_set_t;

  typedef struct {
    word_t fld[9];
    logic  degen;
  } unit_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  word_t vec_x = '0, vec_y = '0, vec_z = '0;
  word_t rate_x = '0, rate_y = '0, rate_z = '0;
  word_t accel_x = '0, accel_y = '0, accel_z = '0;
  logic done;
  word_t unit_x, unit_y, unit_z;
  word_t unit_rate_x, unit_rate_y, unit_rate_z;
  word_t unit_accel_x, unit_accel_y, unit_accel_z;
  logic degenerate;

  unit_vector_with_derivatives dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .done(done),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .unit_rate_x(unit_rate_x), .unit_rate_y(unit_rate_y), .unit_rate_z(unit_rate_z),
    .unit_accel_x(unit_accel_x), .unit_accel_y(unit_accel_y),
    .unit_accel_z(unit_accel_z),
    .degenerate(degenerate)
  );

  vec_set_t  pending_sets[$];
  unit_set_t expected_units[$];
  int        accepted_count = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        gap_left = 0;

  // Clock generation.
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [63:0] magnitude(input longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint limit60(input longint x);
    if (x > LIM_S) return LIM_S;
    if (x < -LIM_S) return -LIM_S;
    return x;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Rounded Q30 product, limited to magnitude 2^60.
  function automatic longint q30_mul(input longint a, input longint b);
    logic [127:0] prod;
    longint r;
    prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    prod = (prod + (128'd1 << 29)) >> 30;
    if (prod > {64'd0, LIM_U}) prod = {64'd0, LIM_U};
    r = longint'(prod[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // Divide one raw component by the norm, giving Q30.
  function automatic longint scale_by_norm(input longint v, input int k,
                                           input logic [63:0] n);
    logic [63:0] x, t, rm, tot;
    x = magnitude(v) << 30;
    t = x / n;
    rm = x % n;
    if (k > 0 && t > (LIM_U >> k)) begin
      tot = LIM_U;
    end else begin
      tot = (t << k) + (2 * (rm << k) + n) / (2 * n);
      if (tot > LIM_U) tot = LIM_U;
    end
    return v < 0 ? -longint'(tot) : longint'(tot);
  endfunction

  function automatic word_t to_q16(input longint x);
    logic [63:0] m;
    m = (magnitude(x) + (64'd1 << (SH_OUT - 1))) >> SH_OUT;
    if (x < 0) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return word_t'(-longint'(m));
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return word_t'(m);
  endfunction

  // Expected unit vector and its derivatives for one vector set.
  function automatic unit_set_t derive_unit(input vec_set_t vs);
    unit_set_t res;
    longint q[3], r[3], c[3], rp[3], cp[3];
    longint rho, gam, w, qdd;
    logic [63:0] s, m, n;
    int k;
    s = 0;
    rho = 0;
    gam = 0;
    w = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      m = magnitude(longint'(vs.vec[i]));
      s = s + m * m;
    end
    if (s == 0) begin
      foreach (res.fld[i]) res.fld[i] = '0;
      res.degen = 1'b1;
      return res;
    end
    while (s < LIM_U) begin
      s = s << 2;
      k++;
    end
    n = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q[i] = scale_by_norm(longint'(vs.vec[i]), k, n);
      r[i] = scale_by_norm(longint'(vs.rate[i]), k, n);
      c[i] = scale_by_norm(longint'(vs.accel[i]), k, n);
      rho += q30_mul(q[i], r[i]);
      gam += q30_mul(q[i], c[i]);
    end
    rho = limit60(rho);
    gam = limit60(gam);
    for (int i = 0; i < 3; i++) begin
      rp[i] = limit60(r[i] - q30_mul(q[i], rho));
      cp[i] = limit60(c[i] - q30_mul(q[i], gam));
      w += q30_mul(rp[i], rp[i]);
    end
    w = limit60(w);
    for (int i = 0; i < 3; i++) begin
      qdd = limit60(cp[i] - 2 * q30_mul(rho, rp[i]) - q30_mul(q[i], w));
      res.fld[i] = to_q16(q[i]);
      res.fld[3 + i] = to_q16(rp[i]);
      res.fld[6 + i] = to_q16(qdd);
    end
    res.degen = 1'b0;
    return res;
  endfunction

  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  // Random value with a random number of significant bits.
  function automatic word_t rand_scaled();
    int bits;
    bits = $urandom_range(1, 31);
    return word_t'($signed($urandom & ((32'd1 << bits) - 1))) *
           (($urandom & 1) ? -1 : 1);
  endfunction

  function automatic vec_set_t make_set(input word_t a[3], input word_t d[3],
                                        input word_t e[3]);
    vec_set_t vs;
    vs.vec = a;
    vs.rate = d;
    vs.accel = e;
    return vs;
  endfunction

  // Driver: bursts of queued beats, random gaps between them, a pause at the drain point.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (accepted_count == DRAIN_POINT && expected_units.size() != 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_sets.size() != 0) begin
      vec_x <= pending_sets[0].vec[0];
      vec_y <= pending_sets[0].vec[1];
      vec_z <= pending_sets[0].vec[2];
      rate_x <= pending_sets[0].rate[0];
      rate_y <= pending_sets[0].rate[1];
      rate_z <= pending_sets[0].rate[2];
      accel_x <= pending_sets[0].accel[0];
      accel_y <= pending_sets[0].accel[1];
      accel_z <= pending_sets[0].accel[2];
      start <= 1'b1;
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(0, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor and acceptance: check each result beat, then log the accepted beat.
  always @(posedge clk) begin
    unit_set_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      got.fld = '{unit_x, unit_y, unit_z, unit_rate_x, unit_rate_y, unit_rate_z,
                  unit_accel_x, unit_accel_y, unit_accel_z};
      got.degen = degenerate;
      if (expected_units.size() == 0) begin
        $display("%0t: result beat with none expected", $realtime);
        error_count++;
      end else begin
        want = expected_units.pop_front();
        foreach (want.fld[i]) begin
          if (got.fld[i] !== want.fld[i]) begin
            $display("%0t: field %0d expected %0d actual %0d", $realtime, i,
                     want.fld[i], got.fld[i]);
            error_count++;
          end
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %b actual %b", $realtime,
                   want.degen, got.degen);
          error_count++;
        end
      end
    end
    if (!rst && start && !busy && pending_sets.size() != 0) begin
      expected_units.push_back(derive_unit(pending_sets.pop_front()));
      accepted_count <= accepted_count + 1;
    end
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    word_t zr[3], mx[3], mn[3], a[3], d[3], e[3];
    int kind;
    zr = '{0, 0, 0};
    mx = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    mn = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: zero vector, extremes, axis vectors, tiny vector with huge derivatives.
    pending_sets.push_back(make_set(zr, zr, zr));
    pending_sets.push_back(make_set(zr, mx, mn));
    pending_sets.push_back(make_set(mx, mx, mx));
    pending_sets.push_back(make_set(mn, mn, mn));
    pending_sets.push_back(make_set(mx, mn, mx));
    pending_sets.push_back(make_set(mn, mx, mn));
    pending_sets.push_back(make_set('{1, 0, 0}, mx, mn));
    pending_sets.push_back(make_set('{0, -1, 0}, mn, mx));
    pending_sets.push_back(make_set('{0, 0, 1}, '{1, 1, 1}, '{-1, 0, 1}));
    pending_sets.push_back(make_set('{32'sh0001_0000, 0, 0}, '{0, 32'sh0001_0000, 0},
                                    '{0, 0, 32'sh0001_0000}));
    pending_sets.push_back(make_set('{-32'sh0001_0000, 0, 0}, zr, zr));
    pending_sets.push_back(make_set('{1, 1, 1}, mn, mn));
    pending_sets.push_back(make_set('{32'sh7FFF_FFFF, 0, 32'sh8000_0000}, zr, mx));
    pending_sets.push_back(make_set('{3, 4, 0}, '{4, -3, 0}, '{0, 0, 5}));

    // Random: full range, small vectors with large derivatives, mixed scales, zero vectors.
    repeat (RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      foreach (a[i]) begin
        case (kind)
          0, 1, 2: begin
            a[i] = rand_word();
            d[i] = rand_word();
            e[i] = rand_word();
          end
          3, 4: begin
            a[i] = word_t'($signed($urandom_range(0, 64))) - 32;
            d[i] = rand_word();
            e[i] = rand_word();
          end
          5: begin
            a[i] = '0;
            d[i] = rand_word();
            e[i] = rand_word();
          end
          default: begin
            a[i] = rand_scaled();
            d[i] = rand_scaled();
            e[i] = rand_scaled();
          end
        endcase
      end
      pending_sets.push_back(make_set(a, d, e));
    end

    wait (pending_sets.size() == 0 && expected_units.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
